// ----- rtl/core/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer: request and pixel
// formats, the queued command format, default geometry and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

  // Default geometry and fixed-point format.
  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 768;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Configuration port.
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned COLOR_W      = 24;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;
  localparam logic        REG_PIXEL_COLOR = 1'b0;

  // Request kinds.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned ADDR_W  = 20;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      in_window;
    logic [ADDR_W-1:0]         pixel_address;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [COORD_W-1:0]        abs_x;
    logic [COORD_W-1:0]        abs_y;
    logic                      neg_x;
    logic                      neg_y;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/dlr_front.sv -----
// ----------------------------------------------------------------------------
// dlr_front
// Accepts requests and classifies them: start requests get their signed
// deltas split into magnitude and direction before they are queued.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_front (
  input  wire logic              in_valid_i,
  input  wire dlr_pkg::in_item_t in_req_i,
  output logic                   in_stall_o,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dlr_pkg::cmd_t          q_cmd_o
);

  logic signed [dlr_pkg::COORD_W:0] dx;
  logic signed [dlr_pkg::COORD_W:0] dy;
  logic [dlr_pkg::COORD_W:0]        ax;
  logic [dlr_pkg::COORD_W:0]        ay;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    dx = {in_req_i.end_x[dlr_pkg::COORD_W-1], in_req_i.end_x}
       - {in_req_i.start_x[dlr_pkg::COORD_W-1], in_req_i.start_x};
    dy = {in_req_i.end_y[dlr_pkg::COORD_W-1], in_req_i.end_y}
       - {in_req_i.start_y[dlr_pkg::COORD_W-1], in_req_i.start_y};
    ax = dx[dlr_pkg::COORD_W] ? -dx : dx;
    ay = dy[dlr_pkg::COORD_W] ? -dy : dy;

    q_cmd_o.kind    = in_req_i.kind;
    q_cmd_o.start_x = in_req_i.start_x;
    q_cmd_o.start_y = in_req_i.start_y;
    // A magnitude never exceeds 65535, so the top bit can be dropped.
    q_cmd_o.abs_x   = ax[dlr_pkg::COORD_W-1:0];
    q_cmd_o.abs_y   = ay[dlr_pkg::COORD_W-1:0];
    q_cmd_o.neg_x   = dx[dlr_pkg::COORD_W];
    q_cmd_o.neg_y   = dy[dlr_pkg::COORD_W];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dlr_fifo.sv -----
// ----------------------------------------------------------------------------
// dlr_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_fifo #(
  parameter int unsigned DEPTH = dlr_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dlr_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output dlr_pkg::cmd_t      data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dlr_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dlr_div.sv -----
// ----------------------------------------------------------------------------
// dlr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_div #(
  parameter int unsigned DIV_W = dlr_pkg::FRAC_BITS + 17,
  parameter int unsigned DEN_W = dlr_pkg::COORD_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // The remainder stays below the divisor, so it fits DEN_W bits.
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !diff[DEN_W+1];

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dlr_back.sv -----
// ----------------------------------------------------------------------------
// dlr_back
// Executes queued commands: sets up segments with two dividers, steps the
// fixed-point position and produces pixels through a two-stage output path.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_back #(
  parameter int unsigned SCREEN_WIDTH  = dlr_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = dlr_pkg::SCREEN_HEIGHT,
  parameter int unsigned FRAC_BITS     = dlr_pkg::FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire dlr_pkg::cmd_t               cmd_i,
  output logic                             cmd_pop_o,
  input  wire logic [dlr_pkg::COLOR_W-1:0] color_i,
  output logic                             out_valid_o,
  output dlr_pkg::out_item_t               out_rsp_o,
  input  wire logic                        out_stall_i
);

  localparam int unsigned CW     = dlr_pkg::COORD_W;
  localparam int unsigned POS_W  = FRAC_BITS + 18;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned DIV_W  = FRAC_BITS + 17;
  localparam int unsigned FL_W   = POS_W - FRAC_BITS;
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned PROD_W = 2 * DIM_W + 2;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } back_state_e;

  back_state_e       state_q, state_d;
  logic              active_q, active_d;
  logic [POS_W-1:0]  pos_x_q, pos_x_d;
  logic [POS_W-1:0]  pos_y_q, pos_y_d;
  logic [STEP_W-1:0] step_x_q, step_x_d;
  logic [STEP_W-1:0] step_y_q, step_y_d;
  logic [CW-1:0]     left_q, left_d;
  logic              neg_x_q, neg_x_d;
  logic              neg_y_q, neg_y_d;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_load;
  logic [POS_W-1:0]  s1_x_q;
  logic [POS_W-1:0]  s1_y_q;
  logic              s1_last_q;
  logic              out_valid_q;
  dlr_pkg::out_item_t out_q;
  logic              out_ready;
  logic              s1_free;

  logic [CW-1:0]     steps_c;
  logic [DIV_W-1:0]  dvd_x, dvd_y;
  logic [DIV_W-1:0]  quo_x, quo_y;
  logic              done_x, done_y;
  logic              div_start;
  logic [STEP_W-1:0] mag_x, mag_y;
  logic [POS_W-1:0]  pos_x_nx, pos_y_nx;

  logic [FL_W-1:0]   x_fl, y_fl;
  logic              x_neg, y_neg;
  logic              x_up, y_up;
  logic              in_win;
  logic [PROD_W-1:0] addr_full;
  dlr_pkg::out_item_t pix;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_free   = !s1_valid_q || out_ready;

  assign steps_c = (cmd_i.abs_x >= cmd_i.abs_y) ? cmd_i.abs_x : cmd_i.abs_y;
  // Adding half the step count before dividing rounds to nearest.
  assign dvd_x = {1'b0, cmd_i.abs_x, {FRAC_BITS{1'b0}}} + DIV_W'(steps_c >> 1);
  assign dvd_y = {1'b0, cmd_i.abs_y, {FRAC_BITS{1'b0}}} + DIV_W'(steps_c >> 1);

  dlr_div #(
    .DIV_W (DIV_W),
    .DEN_W (CW)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (steps_c),
    .done_o     (done_x),
    .quotient_o (quo_x)
  );

  dlr_div #(
    .DIV_W (DIV_W),
    .DEN_W (CW)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (steps_c),
    .done_o     (done_y),
    .quotient_o (quo_y)
  );

  // The quotient never exceeds one unit, so FRAC_BITS+1 bits carry it.
  assign mag_x = {1'b0, quo_x[FRAC_BITS:0]};
  assign mag_y = {1'b0, quo_y[FRAC_BITS:0]};

  assign pos_x_nx = pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
  assign pos_y_nx = pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    left_d     = left_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    cmd_pop_o  = 1'b0;
    div_start  = 1'b0;
    s1_load    = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == dlr_pkg::KIND_START) begin
            cmd_pop_o = 1'b1;
            active_d  = 1'b0;
            pos_x_d   = {{2{cmd_i.start_x[CW-1]}}, cmd_i.start_x, {FRAC_BITS{1'b0}}};
            pos_y_d   = {{2{cmd_i.start_y[CW-1]}}, cmd_i.start_y, {FRAC_BITS{1'b0}}};
            neg_x_d   = cmd_i.neg_x;
            neg_y_d   = cmd_i.neg_y;
            left_d    = steps_c;
            if (steps_c != '0) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else if (!active_q) begin
            cmd_pop_o = 1'b1;
          end else if (s1_free) begin
            cmd_pop_o = 1'b1;
            s1_load   = 1'b1;
            pos_x_d   = pos_x_nx;
            pos_y_d   = pos_y_nx;
            left_d    = left_q - 1'b1;
            if (left_q == CW'(1)) begin
              active_d = 1'b0;
            end
          end
        end
      end
      ST_DIV: begin
        if (done_x && done_y) begin
          step_x_d = neg_x_q ? -mag_x : mag_x;
          step_y_d = neg_y_q ? -mag_y : mag_y;
          active_d = 1'b1;
          state_d  = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  // Pixel fields from the stepped position. Floor values serve the window
  // test and the address; the reported coordinates round toward zero.
  always_comb begin
    x_fl   = s1_x_q[POS_W-1:FRAC_BITS];
    y_fl   = s1_y_q[POS_W-1:FRAC_BITS];
    x_neg  = s1_x_q[POS_W-1];
    y_neg  = s1_y_q[POS_W-1];
    x_up   = x_neg && (|s1_x_q[FRAC_BITS-1:0]);
    y_up   = y_neg && (|s1_y_q[FRAC_BITS-1:0]);
    in_win = !x_neg && !y_neg
          && (x_fl < FL_W'(SCREEN_WIDTH)) && (y_fl < FL_W'(SCREEN_HEIGHT));
    addr_full = PROD_W'(x_fl[DIM_W-1:0])
              + PROD_W'(SCREEN_WIDTH) * PROD_W'(y_fl[DIM_W-1:0]);

    pix.pixel_x       = x_fl[CW-1:0] + CW'(x_up);
    pix.pixel_y       = y_fl[CW-1:0] + CW'(y_up);
    pix.in_window     = in_win;
    pix.pixel_address = in_win ? addr_full[dlr_pkg::ADDR_W-1:0] : '0;
    pix.color         = color_i;
    pix.last          = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      active_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      left_q      <= '0;
      neg_x_q     <= 1'b0;
      neg_y_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      step_x_q   <= step_x_d;
      step_y_q   <= step_y_d;
      left_q     <= left_d;
      neg_x_q    <= neg_x_d;
      neg_y_q    <= neg_y_d;
      s1_valid_q <= s1_valid_d;
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_x_q    <= pos_x_nx;
      s1_y_q    <= pos_y_nx;
      s1_last_q <= (left_q == CW'(1));
    end
    if (out_ready && s1_valid_q) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/dda_line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: turns segment requests into a stream of pixels.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid_i/in_req_i and are held off with in_stall_o.
// A start request loads a segment; each advance request steps it once and
// yields one pixel on out_valid_o/out_rsp_o, which the receiver holds with
// out_stall_i. The start point is never emitted, and neither a zero-length
// segment nor an advance without an active segment produces a pixel.
// An accepted advance passes the s1 stage and then the output register;
// advances run at one pixel per cycle unless the output stalls or a
// division runs. A start request holds the back end while the two bit-serial
// dividers form the per-axis increments; requests queue behind it meanwhile.
// A stalled output keeps its pixel; one more pixel waits in the stage
// behind it and further requests collect in the command queue.
// Reset empties the queue and the pipeline, ends any segment and sets the
// pixel color register (APB offset 0) to white.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_unit #(
  parameter int unsigned SCREEN_WIDTH  = dlr_pkg::SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = dlr_pkg::SCREEN_HEIGHT,
  parameter int unsigned FRAC_BITS     = dlr_pkg::FRAC_BITS,
  parameter int unsigned QUEUE_DEPTH   = dlr_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire dlr_pkg::in_item_t           in_req_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output dlr_pkg::out_item_t               out_rsp_o,
  input  wire logic                        out_stall_i,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dlr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dlr_pkg::PDATA_W-1:0] pwdata,
  output logic [dlr_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [dlr_pkg::COLOR_W-1:0] pixel_color_q;
  logic                        reg_sel;
  logic                        q_full;
  logic                        q_push;
  logic                        q_valid;
  logic                        q_pop;
  dlr_pkg::cmd_t               q_cmd_in;
  dlr_pkg::cmd_t               q_cmd_out;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == dlr_pkg::REG_PIXEL_COLOR);
  assign prdata  = reg_sel
                 ? {{(dlr_pkg::PDATA_W-dlr_pkg::COLOR_W){1'b0}}, pixel_color_q}
                 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_color_q <= dlr_pkg::COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pixel_color_q <= pwdata[dlr_pkg::COLOR_W-1:0];
    end
  end

  dlr_front u_front (
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  dlr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd_out)
  );

  dlr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .color_i     (pixel_color_q),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
